// ----- rtl/core/ssng_pkg.sv -----
// Shared definitions for the step sequencer note grid.
// Holds grid geometry, field widths, opcodes, controller types and the pitch tables.
// No dependencies.
package ssng_pkg;

  localparam int GRID_COLUMNS = 32;
  localparam int NOTE_ROWS    = 7;
  localparam int VOICE_COUNT  = 3;

  localparam int OUT_VOICES   = 3;
  localparam int VOICE_LIMIT  = (VOICE_COUNT < OUT_VOICES) ? VOICE_COUNT : OUT_VOICES;

  localparam int COL_W        = $clog2(GRID_COLUMNS);
  localparam int LEN_W        = $clog2(GRID_COLUMNS + 1);
  localparam int GROUP_SIZE   = 8;
  localparam int GROUPS       = (GRID_COLUMNS + GROUP_SIZE - 1) / GROUP_SIZE;

  localparam int MIN_LOOP     = 4;
  localparam int SHORT_LIMIT  = 3;
  localparam int PITCH_MAX    = 35;
  localparam int PITCHES      = 36;

  localparam int OPCODE_W     = 2;
  localparam int COLUMN_W     = 6;
  localparam int ROW_W        = 3;
  localparam int STEP_W       = 5;
  localparam int COUNT_W      = 2;
  localparam int FREQ_W       = 10;
  localparam int TRANSPOSE_W  = 5;
  localparam int PITCH_W      = 7;
  localparam int PIDX_W       = 6;
  localparam int BASE_W       = 5;

  localparam int PADDR_W      = 3;
  localparam int PDATA_W      = 32;
  localparam int REG_TRANSPOSE = 0;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TOGGLE  = 2'd0,
    OP_CLEAR   = 2'd1,
    OP_ADVANCE = 2'd2,
    OP_HOME    = 2'd3
  } opcode_t;

  typedef logic [NOTE_ROWS-1:0] col_bits_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TREE,
    S_MOD,
    S_SCAN,
    S_LOOK,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic take;
    logic tree_load;
    logic mod_step;
    logic scan_load;
    logic look_load;
    logic emit_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic in_adv;
    logic mod_done;
    logic out_free;
  } ctl_stat_t;

  localparam logic [BASE_W-1:0] ROW_BASE [8] = '{
    5'd0, 5'd23, 5'd21, 5'd19, 5'd17, 5'd16, 5'd14, 5'd12
  };

  localparam logic [FREQ_W-1:0] FREQ_TABLE [PITCHES] = '{
    10'd131, 10'd139, 10'd147, 10'd156, 10'd165, 10'd175,
    10'd185, 10'd196, 10'd208, 10'd220, 10'd233, 10'd247,
    10'd262, 10'd277, 10'd294, 10'd311, 10'd330, 10'd349,
    10'd370, 10'd392, 10'd415, 10'd440, 10'd466, 10'd494,
    10'd523, 10'd554, 10'd587, 10'd622, 10'd659, 10'd698,
    10'd740, 10'd784, 10'd831, 10'd880, 10'd932, 10'd988
  };

endpackage

// ----- rtl/core/ssng_if.sv -----
// Channel interfaces for the step sequencer: command items in, step results out.
// Depends on ssng_pkg for field widths.
interface ssng_cmd_if;
  logic                            valid;
  logic                            ready;
  logic [ssng_pkg::OPCODE_W-1:0]   opcode;
  logic [ssng_pkg::COLUMN_W-1:0]   column;
  logic [ssng_pkg::ROW_W-1:0]      row;

  modport source (output valid, output opcode, output column, output row, input ready);
  modport sink   (input valid, input opcode, input column, input row, output ready);
endinterface

interface ssng_res_if;
  logic                            valid;
  logic                            ready;
  logic [ssng_pkg::STEP_W-1:0]     step_position;
  logic                            played;
  logic [ssng_pkg::COUNT_W-1:0]    voice_count;
  logic [ssng_pkg::FREQ_W-1:0]     voice_a_freq;
  logic [ssng_pkg::FREQ_W-1:0]     voice_b_freq;
  logic [ssng_pkg::FREQ_W-1:0]     voice_c_freq;

  modport source (output valid, output step_position, output played, output voice_count,
                  output voice_a_freq, output voice_b_freq, output voice_c_freq,
                  input ready);
  modport sink   (input valid, input step_position, input played, input voice_count,
                  input voice_a_freq, input voice_b_freq, input voice_c_freq,
                  output ready);
endinterface

// ----- rtl/core/ssng_ctrl.sv -----
// Sequencing controller for the step sequencer.
// Depends on ssng_pkg for state, command and status types.
module ssng_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ssng_pkg::ctl_stat_t  stat,
  output ssng_pkg::ctl_cmd_t   cmd
);

  ssng_pkg::state_t state;
  ssng_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ssng_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ssng_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = stat.in_adv ? ssng_pkg::S_TREE : ssng_pkg::S_EMIT;
        end
      end
      ssng_pkg::S_TREE: state_next = ssng_pkg::S_MOD;
      ssng_pkg::S_MOD: begin
        if (stat.mod_done) begin
          state_next = ssng_pkg::S_SCAN;
        end
      end
      ssng_pkg::S_SCAN: state_next = ssng_pkg::S_LOOK;
      ssng_pkg::S_LOOK: state_next = ssng_pkg::S_EMIT;
      ssng_pkg::S_EMIT: begin
        if (stat.out_free) begin
          state_next = ssng_pkg::S_IDLE;
        end
      end
      default: state_next = ssng_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    case (state)
      ssng_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      ssng_pkg::S_TREE: cmd.tree_load = 1'b1;
      ssng_pkg::S_MOD:  cmd.mod_step  = 1'b1;
      ssng_pkg::S_SCAN: cmd.scan_load = 1'b1;
      ssng_pkg::S_LOOK: cmd.look_load = 1'b1;
      ssng_pkg::S_EMIT: cmd.emit_load = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ----- rtl/core/ssng_datapath.sv -----
// Datapath for the step sequencer: note grid, playhead, loop length search,
// modulo unit, column scan, pitch lookup and output register. Depends on ssng_pkg.
module ssng_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  ssng_pkg::ctl_cmd_t                    cmd,
  output ssng_pkg::ctl_stat_t                   stat,
  input  logic [ssng_pkg::OPCODE_W-1:0]         opcode,
  input  logic [ssng_pkg::COLUMN_W-1:0]         column,
  input  logic [ssng_pkg::ROW_W-1:0]            row,
  input  logic signed [ssng_pkg::TRANSPOSE_W-1:0] transpose,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic [ssng_pkg::STEP_W-1:0]           out_step,
  output logic                                  out_played,
  output logic [ssng_pkg::COUNT_W-1:0]          out_count,
  output logic [ssng_pkg::FREQ_W-1:0]           out_freq [ssng_pkg::OUT_VOICES]
);

  ssng_pkg::col_bits_t                 grid [ssng_pkg::GRID_COLUMNS];
  logic [ssng_pkg::COL_W-1:0]          playhead;
  logic                                adv;

  logic                                grp_any      [ssng_pkg::GROUPS];
  logic [ssng_pkg::COL_W-1:0]          grp_last     [ssng_pkg::GROUPS];
  logic                                grp_any_next [ssng_pkg::GROUPS];
  logic [ssng_pkg::COL_W-1:0]          grp_last_next[ssng_pkg::GROUPS];

  logic [ssng_pkg::COL_W-1:0]          last_col;
  logic [ssng_pkg::LEN_W-1:0]          len_next;
  logic [ssng_pkg::LEN_W-1:0]          loop_len;
  logic [ssng_pkg::LEN_W-1:0]          rem;

  logic [ssng_pkg::ROW_W-1:0]          voice_row      [ssng_pkg::OUT_VOICES];
  logic [ssng_pkg::ROW_W-1:0]          voice_row_next [ssng_pkg::OUT_VOICES];
  logic [ssng_pkg::COUNT_W-1:0]        vcount;
  logic [ssng_pkg::COUNT_W-1:0]        vcount_next;
  logic [ssng_pkg::FREQ_W-1:0]         freq_q    [ssng_pkg::OUT_VOICES];
  logic [ssng_pkg::FREQ_W-1:0]         freq_next [ssng_pkg::OUT_VOICES];

  logic                                toggle_ok;
  ssng_pkg::col_bits_t                 toggle_mask;
  ssng_pkg::col_bits_t                 scan_bits;

  function automatic logic [ssng_pkg::FREQ_W-1:0] row_freq(
    input logic [ssng_pkg::ROW_W-1:0]              r,
    input logic signed [ssng_pkg::TRANSPOSE_W-1:0] tr
  );
    logic signed [ssng_pkg::PITCH_W-1:0] pitch;
    logic [ssng_pkg::PIDX_W-1:0]         idx;
    pitch = $signed({2'b00, ssng_pkg::ROW_BASE[r]}) + ssng_pkg::PITCH_W'(tr);
    if (pitch[ssng_pkg::PITCH_W-1]) begin
      idx = '0;
    end else if (pitch > ssng_pkg::PITCH_W'(ssng_pkg::PITCH_MAX)) begin
      idx = ssng_pkg::PIDX_W'(ssng_pkg::PITCH_MAX);
    end else begin
      idx = pitch[ssng_pkg::PIDX_W-1:0];
    end
    return ssng_pkg::FREQ_TABLE[idx];
  endfunction

  assign toggle_ok   = (int'(column) < ssng_pkg::GRID_COLUMNS) && (row != '0) &&
                       (int'(row) <= ssng_pkg::NOTE_ROWS);
  assign toggle_mask = ssng_pkg::col_bits_t'(1) << (row - ssng_pkg::ROW_W'(1));

  // Grid edits happen at the transfer itself
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < ssng_pkg::GRID_COLUMNS; c++) begin
        grid[c] <= '0;
      end
    end else if (cmd.take) begin
      if (opcode == ssng_pkg::OP_CLEAR) begin
        for (int c = 0; c < ssng_pkg::GRID_COLUMNS; c++) begin
          grid[c] <= '0;
        end
      end else if (opcode == ssng_pkg::OP_TOGGLE && toggle_ok) begin
        for (int c = 0; c < ssng_pkg::GRID_COLUMNS; c++) begin
          if (column == ssng_pkg::COLUMN_W'(c)) begin
            grid[c] <= grid[c] ^ toggle_mask;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      playhead <= '0;
    end else if (cmd.take && opcode == ssng_pkg::OP_HOME) begin
      playhead <= '0;
    end else if (cmd.mod_step && stat.mod_done) begin
      playhead <= rem[ssng_pkg::COL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      adv <= (opcode == ssng_pkg::OP_ADVANCE);
    end
  end

  // First level of the last-occupied-column tree: one register per group of columns
  always_comb begin
    for (int g = 0; g < ssng_pkg::GROUPS; g++) begin
      grp_any_next[g]  = 1'b0;
      grp_last_next[g] = '0;
      for (int j = 0; j < ssng_pkg::GROUP_SIZE; j++) begin
        if (g * ssng_pkg::GROUP_SIZE + j < ssng_pkg::GRID_COLUMNS) begin
          if (|grid[g * ssng_pkg::GROUP_SIZE + j]) begin
            grp_any_next[g]  = 1'b1;
            grp_last_next[g] = ssng_pkg::COL_W'(g * ssng_pkg::GROUP_SIZE + j);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < ssng_pkg::GROUPS; g++) begin
      grp_any[g]  <= grp_any_next[g];
      grp_last[g] <= grp_last_next[g];
    end
  end

  always_comb begin
    last_col = '0;
    for (int g = 0; g < ssng_pkg::GROUPS; g++) begin
      if (grp_any[g]) begin
        last_col = grp_last[g];
      end
    end
    if (last_col < ssng_pkg::COL_W'(ssng_pkg::SHORT_LIMIT)) begin
      len_next = ssng_pkg::LEN_W'(ssng_pkg::MIN_LOOP);
    end else begin
      len_next = ssng_pkg::LEN_W'(last_col) + ssng_pkg::LEN_W'(1);
    end
  end

  // Modulo by repeated subtraction of the loop length
  always_ff @(posedge clk) begin
    if (cmd.tree_load) begin
      loop_len <= len_next;
      rem      <= ssng_pkg::LEN_W'(playhead) + ssng_pkg::LEN_W'(1);
    end else if (cmd.mod_step && !stat.mod_done) begin
      rem <= rem - loop_len;
    end
  end

  // Column scan, top row first
  assign scan_bits = grid[playhead];

  always_comb begin
    vcount_next = '0;
    for (int v = 0; v < ssng_pkg::OUT_VOICES; v++) begin
      voice_row_next[v] = '0;
    end
    for (int r = ssng_pkg::NOTE_ROWS; r >= 1; r--) begin
      if (scan_bits[r-1] && vcount_next < ssng_pkg::COUNT_W'(ssng_pkg::VOICE_LIMIT)) begin
        voice_row_next[vcount_next] = ssng_pkg::ROW_W'(r);
        vcount_next = vcount_next + ssng_pkg::COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_load) begin
      vcount <= vcount_next;
      for (int v = 0; v < ssng_pkg::OUT_VOICES; v++) begin
        voice_row[v] <= voice_row_next[v];
      end
    end
  end

  always_comb begin
    for (int v = 0; v < ssng_pkg::OUT_VOICES; v++) begin
      if (ssng_pkg::COUNT_W'(v) < vcount) begin
        freq_next[v] = row_freq(voice_row[v], transpose);
      end else begin
        freq_next[v] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.look_load) begin
      for (int v = 0; v < ssng_pkg::OUT_VOICES; v++) begin
        freq_q[v] <= freq_next[v];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_step   <= ssng_pkg::STEP_W'(playhead);
      out_played <= adv;
      out_count  <= adv ? vcount : '0;
      for (int v = 0; v < ssng_pkg::OUT_VOICES; v++) begin
        out_freq[v] <= adv ? freq_q[v] : '0;
      end
    end
  end

  assign stat.in_adv   = (opcode == ssng_pkg::OP_ADVANCE);
  assign stat.mod_done = (rem < loop_len);
  assign stat.out_free = !out_valid || out_ready;

endmodule

// ----- rtl/core/step_sequencer_note_grid_top.sv -----
// Step sequencer note grid, top level: channels, configuration register and
// the controller and datapath. Depends on ssng_pkg, ssng_if, ssng_ctrl, ssng_datapath.
//
// Use:
//   cmd carries one item per transfer (opcode, column, row): toggle a note,
//   clear the grid, advance the playhead or send it home to column 0.
//   res carries exactly one result per item: the playhead, a played flag and
//   up to three voice frequencies in hertz taken from the column just reached.
//   The APB port holds one register, transpose, at byte address 0; pready is
//   tied high and writes land on the access cycle. Write it only while idle.
// Sequencing:
//   Toggle, clear and home pass from the idle state straight to the emit state.
//   Advance runs through the tree, modulo, scan, lookup and emit states; the
//   modulo unit subtracts the loop length until the playhead lies inside the
//   loop, so a short loop after a long one takes the most steps. One item is
//   in work at a time; cmd.ready is high only while the controller waits for
//   an item, so the next item is taken only after the last has been emitted.
// Reset and stalls:
//   Reset clears the grid, the playhead, transpose and the output valid flag
//   at once. A result waits in the output register while res.ready is low;
//   the next item is still taken and its result holds back until the
//   register frees.
module step_sequencer_note_grid_top (
  input  logic                          clk,
  input  logic                          rst,
  ssng_cmd_if.sink                      cmd,
  ssng_res_if.source                    res,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ssng_pkg::PADDR_W-1:0]  paddr,
  input  logic [ssng_pkg::PDATA_W-1:0]  pwdata,
  output logic [ssng_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  ssng_pkg::ctl_cmd_t                     ctl_cmd;
  ssng_pkg::ctl_stat_t                    ctl_stat;
  logic signed [ssng_pkg::TRANSPOSE_W-1:0] transpose;
  logic                                   reg_hit;
  logic [ssng_pkg::FREQ_W-1:0]            out_freq [ssng_pkg::OUT_VOICES];

  // Configuration: transpose sits at register index 0, paddr[1:0] is ignored
  assign pready  = 1'b1;
  assign reg_hit = (paddr[ssng_pkg::PADDR_W-1:2] ==
                    (ssng_pkg::PADDR_W-2)'(ssng_pkg::REG_TRANSPOSE));

  always_ff @(posedge clk) begin
    if (rst) begin
      transpose <= '0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      transpose <= pwdata[ssng_pkg::TRANSPOSE_W-1:0];
    end
  end

  assign prdata = (psel && reg_hit) ?
                  ssng_pkg::PDATA_W'(unsigned'(transpose)) : '0;

  ssng_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .in_ready (cmd.ready),
    .stat     (ctl_stat),
    .cmd      (ctl_cmd)
  );

  ssng_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (ctl_cmd),
    .stat       (ctl_stat),
    .opcode     (cmd.opcode),
    .column     (cmd.column),
    .row        (cmd.row),
    .transpose  (transpose),
    .out_ready  (res.ready),
    .out_valid  (res.valid),
    .out_step   (res.step_position),
    .out_played (res.played),
    .out_count  (res.voice_count),
    .out_freq   (out_freq)
  );

  // Voices leave in scan order, top row first
  assign res.voice_a_freq = out_freq[0];
  assign res.voice_b_freq = out_freq[1];
  assign res.voice_c_freq = out_freq[2];

endmodule

// ----- rtl/core/ssng_checker.sv -----
// Port-level checks for the step sequencer, bound to the top level.
// Depends on ssng_pkg for field widths.
module ssng_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         cmd_valid,
  input logic                         cmd_ready,
  input logic                         res_valid,
  input logic                         res_ready,
  input logic                         res_played,
  input logic [ssng_pkg::COUNT_W-1:0] res_count,
  input logic [ssng_pkg::FREQ_W-1:0]  res_a,
  input logic [ssng_pkg::FREQ_W-1:0]  res_b,
  input logic [ssng_pkg::FREQ_W-1:0]  res_c
);

  // One item in work at a time: no transfer in the cycle after a transfer
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |=> !cmd_ready)
    else $error("command taken while previous item still in work");

  // Hold a stalled result
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> res_valid)
    else $error("result dropped while stalled");

  // Items that do not advance carry silent voices
  a_silent: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_played) |->
      (res_count == '0 && res_a == '0 && res_b == '0 && res_c == '0))
    else $error("non-advance result carries voices");

  // Voices beyond the count stay silent, counted voices sound
  a_count_match: assert property (@(posedge clk) disable iff (rst)
    res_valid |->
      ((res_count == 2'd0) == (res_a == '0)) &&
      ((res_count == 2'd0 || res_count == 2'd1) == (res_b == '0)) &&
      ((res_count != 2'd3) == (res_c == '0)))
    else $error("voice frequencies disagree with voice count");

endmodule

bind step_sequencer_note_grid_top ssng_checker u_ssng_checker (
  .clk        (clk),
  .rst        (rst),
  .cmd_valid  (cmd.valid),
  .cmd_ready  (cmd.ready),
  .res_valid  (res.valid),
  .res_ready  (res.ready),
  .res_played (res.played),
  .res_count  (res.voice_count),
  .res_a      (res.voice_a_freq),
  .res_b      (res.voice_b_freq),
  .res_c      (res.voice_c_freq)
);

// ----- tb/step_sequencer_note_grid_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for step_sequencer_note_grid_top: note toggles, grid clears,
// step advances and homing are checked against an in-bench sequencer predictor.
// Depends on ssng_pkg, ssng_if and the RTL of the block.
module step_sequencer_note_grid_top_tb;
  import ssng_pkg::*;

  // One result as it leaves the res channel, packed so that a whole compare is one test.
  typedef struct packed {
    logic [STEP_W-1:0]  step_position;
    logic               played;
    logic [COUNT_W-1:0] voice_count;
    logic [FREQ_W-1:0]  voice_a_freq;
    logic [FREQ_W-1:0]  voice_b_freq;
    logic [FREQ_W-1:0]  voice_c_freq;
  } step_result_t;

  // One command item; pinned rows carry a hand-written expectation that
  // replaces the predicted one.
  typedef struct packed {
    opcode_t             op;
    logic [COLUMN_W-1:0] column;
    logic [ROW_W-1:0]    row;
    logic                pinned;
    step_result_t        want;
  } grid_cmd_t;

  // Pitch tables kept apart from the package, so that a wrong constant in the RTL shows up.
  localparam int ROW_PITCH [8] = '{0, 23, 21, 19, 17, 16, 14, 12};
  localparam int NOTE_HZ [36] = '{
    131, 139, 147, 156, 165, 175, 185, 196, 208, 220, 233, 247,
    262, 277, 294, 311, 330, 349, 370, 392, 415, 440, 466, 494,
    523, 554, 587, 622, 659, 698, 740, 784, 831, 880, 932, 988
  };

  localparam step_result_t NO_PIN = '0;

  // Opening moves, all at transpose 0 straight after reset. Pinned rows: the empty-grid
  // loop of four, out-of-range toggles, the voice limit with four notes in one column,
  // a clear that keeps the playhead, and homing.
  localparam int OPENING_LEN = 24;
  localparam grid_cmd_t OPENING_MOVES [OPENING_LEN] = '{
    '{OP_ADVANCE, 6'd0,  3'd0, 1'b1, '{5'd1, 1'b1, 2'd0, 10'd0, 10'd0, 10'd0}},
    '{OP_ADVANCE, 6'd0,  3'd0, 1'b1, '{5'd2, 1'b1, 2'd0, 10'd0, 10'd0, 10'd0}},
    '{OP_ADVANCE, 6'd0,  3'd0, 1'b1, '{5'd3, 1'b1, 2'd0, 10'd0, 10'd0, 10'd0}},
    '{OP_ADVANCE, 6'd0,  3'd0, 1'b1, '{5'd0, 1'b1, 2'd0, 10'd0, 10'd0, 10'd0}},
    '{OP_TOGGLE,  6'd63, 3'd7, 1'b1, '{5'd0, 1'b0, 2'd0, 10'd0, 10'd0, 10'd0}},
    '{OP_TOGGLE,  6'd32, 3'd1, 1'b1, '{5'd0, 1'b0, 2'd0, 10'd0, 10'd0, 10'd0}},
    '{OP_TOGGLE,  6'd5,  3'd0, 1'b1, '{5'd0, 1'b0, 2'd0, 10'd0, 10'd0, 10'd0}},
    '{OP_TOGGLE,  6'd1,  3'd7, 1'b1, '{5'd0, 1'b0, 2'd0, 10'd0, 10'd0, 10'd0}},
    '{OP_TOGGLE,  6'd1,  3'd1, 1'b1, '{5'd0, 1'b0, 2'd0, 10'd0, 10'd0, 10'd0}},
    '{OP_TOGGLE,  6'd1,  3'd4, 1'b1, '{5'd0, 1'b0, 2'd0, 10'd0, 10'd0, 10'd0}},
    '{OP_TOGGLE,  6'd1,  3'd5, 1'b1, '{5'd0, 1'b0, 2'd0, 10'd0, 10'd0, 10'd0}},
    '{OP_ADVANCE, 6'd0,  3'd0, 1'b1, '{5'd1, 1'b1, 2'd3, 10'd262, 10'd330, 10'd349}},
    '{OP_TOGGLE,  6'd31, 3'd3, 1'b1, '{5'd1, 1'b0, 2'd0, 10'd0, 10'd0, 10'd0}},
    '{OP_ADVANCE, 6'd0,  3'd0, 1'b1, '{5'd2, 1'b1, 2'd0, 10'd0, 10'd0, 10'd0}},
    '{OP_CLEAR,   6'd0,  3'd0, 1'b1, '{5'd2, 1'b0, 2'd0, 10'd0, 10'd0, 10'd0}},
    '{OP_ADVANCE, 6'd0,  3'd0, 1'b1, '{5'd3, 1'b1, 2'd0, 10'd0, 10'd0, 10'd0}},
    '{OP_HOME,    6'd0,  3'd0, 1'b1, '{5'd0, 1'b0, 2'd0, 10'd0, 10'd0, 10'd0}},
    '{OP_TOGGLE,  6'd2,  3'd2, 1'b0, NO_PIN},
    '{OP_TOGGLE,  6'd2,  3'd6, 1'b0, NO_PIN},
    '{OP_TOGGLE,  6'd2,  3'd3, 1'b0, NO_PIN},
    '{OP_ADVANCE, 6'd42, 3'd5, 1'b0, NO_PIN},
    '{OP_ADVANCE, 6'd21, 3'd2, 1'b0, NO_PIN},
    '{OP_TOGGLE,  6'd2,  3'd6, 1'b0, NO_PIN},
    '{OP_ADVANCE, 6'd0,  3'd0, 1'b0, NO_PIN}
  };

  // Random phases: transpose setting, idling percentages and item count. The first
  // phase also carries the long receiver hold-off.
  localparam int PHASES = 7;
  localparam int PHASE_SHIFT [PHASES] = '{-12, 12, -16, 15, 7, -5, 0};
  localparam int PHASE_SEND  [PHASES] = '{  0, 80,   0, 21, 0, 80, 21};
  localparam int PHASE_STALL [PHASES] = '{  0,  0,  80, 21, 0,  0, 21};
  localparam int PHASE_ITEMS [PHASES] = '{ 70, 60,  60, 70, 70, 60, 90};

  logic                 clk;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  ssng_cmd_if cmd_ch ();
  ssng_res_if res_ch ();

  step_sequencer_note_grid_top DUT (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor state: the grid, the playhead and the transpose register as last written.
  col_bits_t                     note_rows [GRID_COLUMNS];
  int                            playhead;
  logic signed [TRANSPOSE_W-1:0] semitone_shift;

  step_result_t expected_steps [$];
  grid_cmd_t    issued_cmds [$];
  int           mismatches     = 0;
  int           send_idle_pct  = 0;
  int           recv_stall_pct = 0;
  bit           hold_request   = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic flag_error(input string what);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] %s", $time, what);
  endtask

  // Frequency of one row at the current transpose, pitch index clamped to the table.
  function automatic int row_hz(input int r);
    int idx;
    idx = ROW_PITCH[r] + int'(semitone_shift);
    if (idx < 0) idx = 0;
    if (idx > PITCH_MAX) idx = PITCH_MAX;
    return NOTE_HZ[idx];
  endfunction

  // Apply one command to the predictor state and return the result it must produce.
  function automatic step_result_t sequencer_response(input opcode_t op,
      input logic [COLUMN_W-1:0] column, input logic [ROW_W-1:0] row);
    step_result_t out;
    col_bits_t    bits;
    int           last, span, taken;
    int           hz [3];
    out   = '0;
    hz    = '{0, 0, 0};
    taken = 0;
    case (op)
      OP_TOGGLE: begin
        if (column < GRID_COLUMNS && row >= 1 && row <= NOTE_ROWS)
          note_rows[column][row-1] = ~note_rows[column][row-1];
      end
      OP_CLEAR: begin
        foreach (note_rows[c]) note_rows[c] = '0;
      end
      OP_ADVANCE: begin
        last = 0;
        for (int c = 0; c < GRID_COLUMNS; c++)
          if (note_rows[c] != '0) last = c;
        span     = (last < SHORT_LIMIT) ? MIN_LOOP : last + 1;
        playhead = (playhead + 1) % span;
        bits     = note_rows[playhead];
        for (int r = NOTE_ROWS; r >= 1; r--) begin
          if (bits[r-1] && taken < VOICE_LIMIT) begin
            hz[taken] = row_hz(r);
            taken++;
          end
        end
        out.played = 1'b1;
      end
      OP_HOME: begin
        playhead = 0;
      end
    endcase
    out.step_position = STEP_W'(playhead);
    out.voice_count   = COUNT_W'(taken);
    out.voice_a_freq  = FREQ_W'(hz[0]);
    out.voice_b_freq  = FREQ_W'(hz[1]);
    out.voice_c_freq  = FREQ_W'(hz[2]);
    return out;
  endfunction

  // Mixed random item: mostly in-range toggles and advances, some clears and homes,
  // a share of short-loop columns and a share of out-of-range columns.
  function automatic grid_cmd_t random_cmd();
    grid_cmd_t c;
    int        pick;
    c    = '0;
    pick = $urandom_range(99);
    c.op = (pick < 45) ? OP_TOGGLE : (pick < 85) ? OP_ADVANCE :
           (pick < 90) ? OP_CLEAR : OP_HOME;
    pick = $urandom_range(9);
    if (pick == 0)     c.column = COLUMN_W'($urandom_range(63));
    else if (pick < 4) c.column = COLUMN_W'($urandom_range(5));
    else               c.column = COLUMN_W'($urandom_range(GRID_COLUMNS - 1));
    c.row = ROW_W'($urandom_range(7));
    return c;
  endfunction

  // Offer one item on cmd and hold it until the transfer. Called in the time step of a
  // rising edge; valid is only dropped when a gap is drawn, so back-to-back items keep
  // valid high without a second assignment in the same step.
  task automatic offer(input grid_cmd_t item);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    issued_cmds.push_back(item);
    cmd_ch.valid  <= 1'b1;
    cmd_ch.opcode <= item.op;
    cmd_ch.column <= item.column;
    cmd_ch.row    <= item.row;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
  endtask

  // Drop valid and wait until every expected result has been taken, then let the
  // block run out its longest advance before anything else touches it.
  task automatic settle();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_steps.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // APB write of transpose: setup cycle, then access cycle until pready.
  task automatic write_transpose(input logic signed [TRANSPOSE_W-1:0] shift);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * REG_TRANSPOSE);
    pwdata  <= PDATA_W'(shift);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    semitone_shift = shift;
  endtask

  // Receiver: stall at the phase's rate, or hold off for a long stretch on request so
  // that the block fills up and drops cmd.ready.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_left    = 80;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Monitor: predict on every cmd transfer, check every res transfer against the
  // oldest expectation. Values are those from before the edge, so no race with drivers.
  always @(posedge clk) begin : monitor
    grid_cmd_t    sent;
    step_result_t due;
    step_result_t seen;
    if (!rst) begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        sent = issued_cmds.pop_front();
        due  = sequencer_response(opcode_t'(cmd_ch.opcode), cmd_ch.column, cmd_ch.row);
        if (sent.pinned) due = sent.want;
        expected_steps.push_back(due);
      end
      if (res_ch.valid && res_ch.ready) begin
        seen = '{res_ch.step_position, res_ch.played, res_ch.voice_count,
                 res_ch.voice_a_freq, res_ch.voice_b_freq, res_ch.voice_c_freq};
        if (expected_steps.size() == 0) begin
          flag_error($sformatf("result with nothing expected: step %0d played %0b",
                               seen.step_position, seen.played));
        end else begin
          due = expected_steps.pop_front();
          if (seen !== due)
            flag_error($sformatf(
              "step/played/count/a/b/c expected %0d %0b %0d %0d %0d %0d, got %0d %0b %0d %0d %0d %0d",
              due.step_position, due.played, due.voice_count,
              due.voice_a_freq, due.voice_b_freq, due.voice_c_freq,
              seen.step_position, seen.played, seen.voice_count,
              seen.voice_a_freq, seen.voice_b_freq, seen.voice_c_freq));
        end
      end
    end
  end

  initial begin : stimulus
    // Drive every input to a known value and clear the predictor before the first edge.
    rst           <= 1'b1;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    cmd_ch.valid  <= 1'b0;
    cmd_ch.opcode <= OP_TOGGLE;
    cmd_ch.column <= '0;
    cmd_ch.row    <= '0;
    foreach (note_rows[c]) note_rows[c] = '0;
    playhead       = 0;
    semitone_shift = '0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Opening moves with no idling on either side.
    foreach (OPENING_MOVES[i]) offer(OPENING_MOVES[i]);

    // Random phases: drain, write transpose while idle, then stream items.
    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_transpose(TRANSPOSE_W'(PHASE_SHIFT[p]));
      send_idle_pct  = PHASE_SEND[p];
      recv_stall_pct = PHASE_STALL[p];
      for (int i = 0; i < PHASE_ITEMS[p]; i++) begin
        // Hold the receiver off early in the first phase while items keep coming.
        if (p == 0 && i == 20) hold_request = 1'b1;
        offer(random_cmd());
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
